>>> rtl/core/sha_pkg.sv
// Package for the SHA-256 stream hasher: widths, state codes, round constants,
// initial hash values and a rotate function. Depends on nothing.
package sha_pkg;

    localparam int LengthCountBits = 61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    // Reason a compression was started; tells the sequencer where to go next.
    typedef enum logic [1:0] {
        CMP_DATA,
        CMP_PAD_FIRST,
        CMP_PAD_LAST,
        CMP_SECOND
    } cmp_kind_t;

    typedef struct packed {
        logic start;
        logic step;
    } rnd_ctrl_t;

    localparam logic [31:0] PadByte = 32'h0000_0080;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            unique case (idx)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        begin
            unique case (idx)
                3'd0: h = 32'h6a09e667;
                3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372;
                3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f;
                3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab;
                default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/core/sha_round.sv
// Shared SHA-256 round unit: working variables plus a 16-word rolling
// message schedule, one round per step. Depends on sha_pkg.
module sha_round (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::rnd_ctrl_t ctrl,
    input  logic [5:0]         round_idx,
    input  logic [31:0]        blk_in [16],
    input  logic [31:0]        chain_in [8],
    output logic [31:0]        vars_out [8]
);

    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] s0, s1, w_new, t1, t2, e, a, wi;

    always_comb
    begin
        s0 = sha_pkg::ror32(w_reg[1], 7) ^ sha_pkg::ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::ror32(w_reg[14], 17) ^ sha_pkg::ror32(w_reg[14], 19)
           ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        wi = w_reg[0];
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (sha_pkg::ror32(e, 6) ^ sha_pkg::ror32(e, 11) ^ sha_pkg::ror32(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::round_k(round_idx) + wi;
        t2 = (sha_pkg::ror32(a, 2) ^ sha_pkg::ror32(a, 13) ^ sha_pkg::ror32(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next = v_reg;
        w_next = w_reg;
        if (ctrl.start)
        begin
            v_next = chain_in;
            w_next = blk_in;
        end
        else if (ctrl.step)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= '0;
            end
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    assign vars_out = v_reg;

endmodule

>>> rtl/core/sha256_stream_hasher_core.sv
// SHA-256 stream hasher core: byte packer, block padding, sequencer and
// digest output. One iterative round unit (sha_round) does all compression.
// A byte that fills a block stalls input while it is compressed (64 rounds, then
// a chain add). Other bytes do not stall. Message end: a pad step, then a compression
// per padding block (1 or 2, 1 more in double mode), then 8 output transactions.
// Reset (rst_n, asynchronous, low) restores the initial hash and clears count.
module sha256_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam int CntW = sha_pkg::LengthCountBits;

    sha_pkg::state_t    state_reg, state_next;
    sha_pkg::cmp_kind_t kind_reg, kind_next;
    sha_pkg::rnd_ctrl_t rctrl;

    logic            dbl_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic [5:0]      round_reg, round_next;
    logic [2:0]      oidx_reg, oidx_next;
    logic            pend_end_reg, pend_end_next;
    logic [31:0]     blk_reg [16];
    logic [31:0]     blk_next [16];
    logic [31:0]     chain_reg [8];
    logic [31:0]     chain_next [8];
    logic [31:0]     vars [8];
    logic            in_fire;
    logic [5:0]      pos;
    logic [63:0]     bits;

    sha_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (rctrl),
        .round_idx(round_reg),
        .blk_in   (blk_next),
        .chain_in (chain_next),
        .vars_out (vars)
    );

    assign in_ready = (state_reg == sha_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_valid = (state_reg == sha_pkg::ST_OUT);
    assign digest_word = chain_reg[oidx_reg];
    assign word_index = oidx_reg;
    assign last_word = (oidx_reg == 3'd7);
    assign pos = count_reg[5:0];
    assign bits = 64'({count_reg, 3'b000});

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        count_next = count_reg;
        round_next = round_reg;
        oidx_next = oidx_reg;
        pend_end_next = pend_end_reg;
        blk_next = blk_reg;
        chain_next = chain_reg;
        rctrl = '0;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    pend_end_next = end_of_message;
                    if (has_byte)
                    begin
                        // Big-endian packing; the first byte of a word clears it.
                        if (pos[1:0] == 2'd0)
                        begin
                            blk_next[pos[5:2]] = {data_byte, 24'h0};
                        end
                        else
                        begin
                            blk_next[pos[5:2]][(5'd24 - {pos[1:0], 3'b000}) +: 8] = data_byte;
                        end
                        count_next = count_reg + 1'b1;
                        if (pos == 6'd63)
                        begin
                            kind_next = sha_pkg::CMP_DATA;
                            rctrl.start = 1'b1;
                            round_next = '0;
                            state_next = sha_pkg::ST_ROUND;
                        end
                        else if (end_of_message)
                        begin
                            state_next = sha_pkg::ST_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                // Append the marker byte, clear the tail, and place the length
                // when it fits in this block.
                for (int i = 0; i < 16; i++)
                begin
                    if (4'(i) > pos[5:2])
                    begin
                        blk_next[i] = '0;
                    end
                end
                blk_next[pos[5:2]][(5'd24 - {pos[1:0], 3'b000}) +: 8] = sha_pkg::PadByte[7:0];
                if (pos[1:0] != 2'd3)
                begin
                    blk_next[pos[5:2]][(5'd16 - {pos[1:0], 3'b000}) +: 8] = 8'h0;
                end
                if (pos[1:0] == 2'd0)
                begin
                    blk_next[pos[5:2]][7:0] = 8'h0;
                    blk_next[pos[5:2]][15:8] = 8'h0;
                end
                else if (pos[1:0] == 2'd1)
                begin
                    blk_next[pos[5:2]][7:0] = 8'h0;
                end
                if (pos >= 6'd56)
                begin
                    kind_next = sha_pkg::CMP_PAD_FIRST;
                end
                else
                begin
                    blk_next[14] = bits[63:32];
                    blk_next[15] = bits[31:0];
                    kind_next = sha_pkg::CMP_PAD_LAST;
                end
                rctrl.start = 1'b1;
                round_next = '0;
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND:
            begin
                rctrl.step = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                round_next = '0;
                unique case (kind_reg)
                    sha_pkg::CMP_DATA:
                    begin
                        state_next = pend_end_reg ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
                    end
                    sha_pkg::CMP_PAD_FIRST:
                    begin
                        for (int i = 0; i < 14; i++)
                        begin
                            blk_next[i] = '0;
                        end
                        blk_next[14] = bits[63:32];
                        blk_next[15] = bits[31:0];
                        kind_next = sha_pkg::CMP_PAD_LAST;
                        rctrl.start = 1'b1;
                        state_next = sha_pkg::ST_ROUND;
                    end
                    sha_pkg::CMP_PAD_LAST:
                    begin
                        if (dbl_reg)
                        begin
                            // Rehash the 32-byte digest as a single padded block.
                            for (int i = 0; i < 8; i++)
                            begin
                                blk_next[i] = chain_next[i];
                                chain_next[i] = sha_pkg::init_h(3'(i));
                            end
                            blk_next[8] = 32'h8000_0000;
                            for (int i = 9; i < 15; i++)
                            begin
                                blk_next[i] = '0;
                            end
                            blk_next[15] = 32'd256;
                            kind_next = sha_pkg::CMP_SECOND;
                            rctrl.start = 1'b1;
                            state_next = sha_pkg::ST_ROUND;
                        end
                        else
                        begin
                            oidx_next = '0;
                            state_next = sha_pkg::ST_OUT;
                        end
                    end
                    default:
                    begin
                        oidx_next = '0;
                        state_next = sha_pkg::ST_OUT;
                    end
                endcase
            end
            sha_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 1'b1;
                    if (oidx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_next[i] = sha_pkg::init_h(3'(i));
                        end
                        count_next = '0;
                        pend_end_next = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            kind_reg <= sha_pkg::CMP_DATA;
            count_reg <= '0;
            round_reg <= '0;
            oidx_reg <= '0;
            pend_end_reg <= 1'b0;
            dbl_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::init_h(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            count_reg <= count_next;
            round_reg <= round_next;
            oidx_reg <= oidx_next;
            pend_end_reg <= pend_end_next;
            chain_reg <= chain_next;
            if (cfg_we)
            begin
                dbl_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

`ifndef NO_ASSERTIONS
    // The round counter only moves while a compression is running.
    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_IDLE) |-> (round_reg == 6'd0))
        else $error("round counter not cleared while idle");
    // Results follow only the last round and a chain add.
    a_out_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == sha_pkg::ST_ADD))
        else $error("output started without a chain add");
    // After the eighth word the block returns to idle with a cleared count.
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> (in_ready && count_reg == '0))
        else $error("state not restored after digest");
`endif

endmodule
